[rtl/core/fbpa_pkg.sv]
// Shared types and constants for the fixed block pool allocator.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.

package fbpa_pkg;

  // Address width of the item fields and the base register.
  localparam int ADDR_W = 32;
  // Chunk size is the header plus up to 65535 item bytes.
  localparam int CHUNK_W = 17;

  // Request opcodes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_BADADDR = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_BASE    = 2'd0;
  localparam logic [1:0] REG_SLOTS   = 2'd1;
  localparam logic [1:0] REG_ITEM    = 2'd2;
  localparam logic [1:0] REG_ENABLE  = 2'd3;

  // Command kinds passed from the front to the back.
  localparam logic [1:0] K_ALLOC  = 2'd0;
  localparam logic [1:0] K_FREE   = 2'd1;
  localparam logic [1:0] K_REJECT = 2'd2;

  // Command queue depth.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] item_address;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_address;
    logic [10:0]       slot_count;
    logic [15:0]       item_bytes;
    logic              pool_enabled;
  } cfg_t;

  // A classified request: kind, status for a rejected one, and for a free
  // the byte offset of the address from the first item address.
  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        status;
    logic [ADDR_W-1:0] rel;
  } cmd_t;

endpackage

[rtl/core/fbpa_front.sv]
// Front end of the allocator: accepts request items and classifies them.
// Depends on fbpa_pkg; feeds fbpa_cmd_fifo.

module fbpa_front #(
  parameter int MAX_SLOTS    = 1024,
  parameter int HEADER_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fbpa_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  fbpa_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output fbpa_pkg::cmd_t    q_data
);

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int DW     = fbpa_pkg::ADDR_W + SLOT_W;

  logic                        st_valid_r, st_valid_nxt;
  logic                        st_op_r;
  logic [fbpa_pkg::ADDR_W-1:0] st_off_r;
  logic                        accept;
  logic [fbpa_pkg::CHUNK_W-1:0] chunk;
  logic [fbpa_pkg::ADDR_W-1:0] rel;
  logic                        hdr_ok;
  logic                        range_ok;

  // The stage holds one item; it stalls only while the queue is full.
  assign in_stall = st_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = st_valid_r && !q_full;

  always_comb begin
    st_valid_nxt = st_valid_r;
    if (accept) begin
      st_valid_nxt = 1'b1;
    end else if (q_push) begin
      st_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
  end

  // Offset from the pool base is taken on entry, modulo the address width.
  always_ff @(posedge clk) begin
    if (accept) begin
      st_op_r  <= in_data.opcode;
      st_off_r <= in_data.free_address - cfg.base_address;
    end
  end

  // A free is plausible when the offset clears the first header and the
  // quotient by the chunk size fits the slot index.
  assign chunk    = fbpa_pkg::CHUNK_W'(HEADER_BYTES) + fbpa_pkg::CHUNK_W'(cfg.item_bytes);
  assign hdr_ok   = st_off_r >= fbpa_pkg::ADDR_W'(HEADER_BYTES);
  assign rel      = st_off_r - fbpa_pkg::ADDR_W'(HEADER_BYTES);
  assign range_ok = DW'(rel) < (DW'(chunk) << SLOT_W);

  // Classification into the command for the back end.
  always_comb begin
    q_data.rel    = rel;
    q_data.status = fbpa_pkg::ST_OK;
    priority if (!cfg.pool_enabled) begin
      q_data.kind   = fbpa_pkg::K_REJECT;
      q_data.status = fbpa_pkg::ST_INVALID;
    end else if (st_op_r == fbpa_pkg::OP_ALLOC) begin
      q_data.kind = fbpa_pkg::K_ALLOC;
    end else if (hdr_ok && range_ok) begin
      q_data.kind = fbpa_pkg::K_FREE;
    end else begin
      q_data.kind   = fbpa_pkg::K_REJECT;
      q_data.status = fbpa_pkg::ST_BADADDR;
    end
  end

endmodule

[rtl/core/fbpa_cmd_fifo.sv]
// Short command queue between the front and the back of the allocator.
// Depends on fbpa_pkg for the command type and the depth.

module fbpa_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fbpa_pkg::cmd_t push_data,
  input  logic           pop,
  output fbpa_pkg::cmd_t pop_data,
  output logic           full,
  output logic           empty
);

  fbpa_pkg::cmd_t                 slot_r [fbpa_pkg::CMDQ_DEPTH];
  logic [fbpa_pkg::CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [fbpa_pkg::CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [fbpa_pkg::CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == fbpa_pkg::CMDQ_CNT_W'(fbpa_pkg::CMDQ_DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = slot_r[rd_ptr_r];

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == fbpa_pkg::CMDQ_PTR_W'(fbpa_pkg::CMDQ_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == fbpa_pkg::CMDQ_PTR_W'(fbpa_pkg::CMDQ_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/fbpa_back.sv]
// Back end of the allocator: free list, link memory, slot divider and
// address multiplier, plus the result register. Depends on fbpa_pkg.

module fbpa_back #(
  parameter int MAX_SLOTS    = 1024,
  parameter int HEADER_BYTES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fbpa_pkg::cfg_t     cfg,
  input  logic               init,
  input  logic               q_empty,
  input  fbpa_pkg::cmd_t     q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output fbpa_pkg::out_item_t out_data
);

  localparam int SLOT_W  = $clog2(MAX_SLOTS);
  localparam int LINK_W  = SLOT_W + 1;
  localparam int DW      = fbpa_pkg::ADDR_W + SLOT_W;
  localparam int DSR_W   = fbpa_pkg::CHUNK_W + SLOT_W - 1;
  localparam int PROD_W  = fbpa_pkg::CHUNK_W + SLOT_W;
  localparam int STEP_W  = $clog2(SLOT_W + 1);
  localparam logic [LINK_W-1:0] LIST_END = LINK_W'(MAX_SLOTS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LINK = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FCHK = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]                   state_r, state_nxt;
  logic [LINK_W-1:0]            free_head_r, free_head_nxt;
  logic [LINK_W-1:0]            fresh_r, fresh_nxt;
  logic [SLOT_W-1:0]            slot_r, slot_nxt;
  logic [PROD_W-1:0]            prod_r;
  logic [fbpa_pkg::ADDR_W-1:0]  rem_r, rem_nxt;
  logic [DSR_W-1:0]             dsr_r, dsr_nxt;
  logic [SLOT_W-1:0]            quo_r, quo_nxt;
  logic [STEP_W-1:0]            step_r, step_nxt;
  logic [1:0]                   res_status_r, res_status_nxt;
  logic [fbpa_pkg::ADDR_W-1:0]  res_addr_r, res_addr_nxt;
  logic                         out_valid_r, out_valid_nxt;
  fbpa_pkg::out_item_t          out_item_r, out_item_nxt;
  logic [LINK_W-1:0]            link_mem [MAX_SLOTS];
  logic [LINK_W-1:0]            rd_data_r;
  logic                         mem_re;
  logic                         mem_we;
  logic [LINK_W-1:0]            live_count;
  logic [fbpa_pkg::CHUNK_W-1:0] chunk;
  logic                         div_ge;

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Slot counts above the memory depth act as the depth.
  assign live_count = (32'(cfg.slot_count) > 32'(MAX_SLOTS)) ? LIST_END :
                      LINK_W'(cfg.slot_count);
  assign chunk  = fbpa_pkg::CHUNK_W'(HEADER_BYTES) + fbpa_pkg::CHUNK_W'(cfg.item_bytes);
  assign div_ge = DW'(rem_r) >= DW'(dsr_r);

  // Sequencer: one command at a time from the queue.
  always_comb begin
    state_nxt      = state_r;
    free_head_nxt  = free_head_r;
    fresh_nxt      = fresh_r;
    slot_nxt       = slot_r;
    rem_nxt        = rem_r;
    dsr_nxt        = dsr_r;
    quo_nxt        = quo_r;
    step_nxt       = step_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_item_nxt   = out_item_r;
    q_pop          = 1'b0;
    mem_re         = 1'b0;
    mem_we         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_data.kind)
            fbpa_pkg::K_ALLOC: begin
              // Freed slots first, then never-used slots in order.
              priority if (free_head_r < live_count) begin
                slot_nxt  = free_head_r[SLOT_W-1:0];
                mem_re    = 1'b1;
                state_nxt = S_LINK;
              end else if (fresh_r < live_count) begin
                free_head_nxt = LIST_END;
                slot_nxt      = fresh_r[SLOT_W-1:0];
                fresh_nxt     = fresh_r + 1'b1;
                state_nxt     = S_MUL;
              end else begin
                free_head_nxt  = LIST_END;
                res_status_nxt = fbpa_pkg::ST_EMPTY;
                res_addr_nxt   = '0;
                state_nxt      = S_DONE;
              end
            end
            fbpa_pkg::K_FREE: begin
              rem_nxt   = q_data.rel;
              dsr_nxt   = DSR_W'(chunk) << (SLOT_W - 1);
              quo_nxt   = '0;
              step_nxt  = STEP_W'(SLOT_W - 1);
              state_nxt = S_DIV;
            end
            default: begin
              res_status_nxt = q_data.status;
              res_addr_nxt   = '0;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_LINK: begin
        free_head_nxt = rd_data_r;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        res_status_nxt = fbpa_pkg::ST_OK;
        res_addr_nxt   = cfg.base_address + fbpa_pkg::ADDR_W'(prod_r) +
                         fbpa_pkg::ADDR_W'(HEADER_BYTES);
        state_nxt      = S_DONE;
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (div_ge) begin
          rem_nxt = fbpa_pkg::ADDR_W'(DW'(rem_r) - DW'(dsr_r));
        end
        quo_nxt = SLOT_W'({quo_r, div_ge});
        dsr_nxt = dsr_r >> 1;
        if (step_r == '0) begin
          state_nxt = S_FCHK;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      S_FCHK: begin
        // Exact chunk boundary inside the live slots: push onto the list.
        res_addr_nxt = '0;
        if (rem_r == '0 && LINK_W'(quo_r) < live_count) begin
          mem_we         = 1'b1;
          free_head_nxt  = LINK_W'(quo_r);
          res_status_nxt = fbpa_pkg::ST_OK;
        end else begin
          res_status_nxt = fbpa_pkg::ST_BADADDR;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: res_status_r, item_address: res_addr_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A configuration write empties the free list and makes every slot never-used again, in order.
    if (init) begin
      free_head_nxt = LIST_END;
      fresh_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= LIST_END;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers; the product is registered ahead of the address add.
  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    rem_r        <= rem_nxt;
    dsr_r        <= dsr_nxt;
    quo_r        <= quo_nxt;
    step_r       <= step_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_item_r   <= out_item_nxt;
    prod_r       <= PROD_W'(slot_r) * PROD_W'(chunk);
  end

  // Link memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[quo_r] <= free_head_r;
    end
    if (mem_re) begin
      rd_data_r <= link_mem[free_head_r[SLOT_W-1:0]];
    end
  end

  // The list head is always a slot index or the end marker.
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= LIST_END)
    else $error("free list head beyond end marker");

  // Never-used slots are handed out only up to the live count.
  a_fresh_range: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= live_count)
    else $error("fresh slot pointer past slot count");

  // A configuration write leaves the whole pool free in order.
  a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
    init |=> (free_head_r == LIST_END && fresh_r == '0))
    else $error("list not re-initialized after configuration write");

  // The front's range check keeps the remainder below twice the divisor.
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> (DW + 1)'(rem_r) < ((DW + 1)'(dsr_r) << 1))
    else $error("divider remainder out of range");

endmodule

[rtl/core/fixed_block_pool_allocator.sv]
// Top level of the fixed block pool allocator: configuration registers and
// the front, queue and back. Depends on fbpa_pkg, fbpa_front, fbpa_cmd_fifo, fbpa_back.
//
//   Port group   Direction  Handshake             Carries
//   in_*         input      in_valid / in_stall   opcode, free_address
//   out_*        output     out_valid / out_stall status, item_address
//   p*           APB slave  psel/penable/pready   base, slot count, item bytes, enable
//
// A reject (pool disabled, or a free address inside the first header or past
// MAX_SLOTS chunks) goes straight to the result state; an allocate passes multiply
// and add, after a link memory read when it takes a freed slot; any other free
// runs the one-bit-per-cycle slot divider and a boundary check. The front stage
// adds a register ahead of the command queue.
// Reset is synchronous on rst_n and leaves the pool disabled with all slots free.
// A stalled result holds in the output register while the front and the
// two-entry command queue keep taking items until the queue fills.

module fixed_block_pool_allocator #(
  parameter int MAX_SLOTS    = 1024,
  parameter int HEADER_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fbpa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fbpa_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  fbpa_pkg::cfg_t cfg_r, cfg_nxt;
  logic           cfg_wr;
  logic [1:0]     reg_idx;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  fbpa_pkg::cmd_t q_in;
  fbpa_pkg::cmd_t q_out;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        fbpa_pkg::REG_BASE:   cfg_nxt.base_address = pwdata;
        fbpa_pkg::REG_SLOTS:  cfg_nxt.slot_count   = pwdata[10:0];
        fbpa_pkg::REG_ITEM:   cfg_nxt.item_bytes   = pwdata[15:0];
        fbpa_pkg::REG_ENABLE: cfg_nxt.pool_enabled = pwdata[0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{base_address: '0, slot_count: 11'd1, item_bytes: 16'd4,
                 pool_enabled: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx)
      fbpa_pkg::REG_BASE:   prdata = cfg_r.base_address;
      fbpa_pkg::REG_SLOTS:  prdata = 32'(cfg_r.slot_count);
      fbpa_pkg::REG_ITEM:   prdata = 32'(cfg_r.item_bytes);
      fbpa_pkg::REG_ENABLE: prdata = 32'(cfg_r.pool_enabled);
      default:              prdata = '0;
    endcase
  end

  fbpa_front #(
    .MAX_SLOTS    (MAX_SLOTS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  fbpa_cmd_fifo u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  fbpa_back #(
    .MAX_SLOTS    (MAX_SLOTS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .init      (cfg_wr),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
